[rtl/epam_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the Euler pose to affine matrix pipeline.
// No dependencies.
package epam_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int TRIG_BITS  = 16;

	// pi * 2^32, rounded
	localparam logic [63:0] PI_Q32 = 64'h0000_0003_243F_6A89;

	localparam int TERMS    = 7;
	// angle prep (3) + three sub-stages per series term + sign fixup
	localparam int TRIG_LAT = 3 + 3 * TERMS + 1;
	localparam int MAT_LAT  = 6;

	// running state of the octant series, one per term boundary
	typedef struct packed {
		logic [31:0] x2;
		logic [31:0] st;
		logic [32:0] ct;
		logic [32:0] s;
		logic [32:0] c;
		logic [1:0]  quad;
		logic        swap;
	} trm_t;

	// scale and translation riding alongside the angles
	typedef struct packed {
		logic signed [31:0] k;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
	} side_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m03;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m13;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] m23;
	} mtx_t;

endpackage

[rtl/epam_trig.sv]
`timescale 1ns / 1ps
// Pipelined sine/cosine of a binary angle: octant reduction, Taylor series
// one term per three stages, quadrant sign fixup. Uses epam_pkg.
module epam_trig #(
	parameter int ANGLE_BITS = epam_pkg::ANGLE_BITS,
	parameter int TRIG_BITS  = epam_pkg::TRIG_BITS
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ANGLE_BITS-1:0]       angle,
	output logic signed [TRIG_BITS+1:0] sine,
	output logic signed [TRIG_BITS+1:0] cosine
);

	localparam int SH = 32 - ANGLE_BITS;
	localparam int PW = ANGLE_BITS - 2;
	localparam int RS = 32 - TRIG_BITS;

	logic [PW-1:0] ua_w;
	logic [PW-1:0] phi_w;
	logic [PW:0]   flip_w;
	logic          swap_w;

	assign ua_w   = angle[PW-1:0];
	assign swap_w = angle[PW-1];
	assign flip_w = ((PW+1)'(1) << PW) - {1'b0, ua_w};
	assign phi_w  = swap_w ? flip_w[PW-1:0] : ua_w;

	logic [63:0] prod_s1;
	logic [1:0]  quad_s1;
	logic        swap_s1;
	logic [31:0] x_s2;
	logic [1:0]  quad_s2;
	logic        swap_s2;
	logic [63:0] xr_w;
	logic [63:0] xx_w;

	epam_pkg::trm_t step_s [0:epam_pkg::TERMS];

	assign xr_w = (prod_s1 << SH) + 64'h0000_0000_4000_0000;
	assign xx_w = 64'(x_s2) * 64'(x_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 64'(phi_w) * epam_pkg::PI_Q32;
			quad_s1 <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
			swap_s1 <= swap_w;
			x_s2    <= xr_w[62:31];
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
			step_s[0].x2   <= xx_w[63:32];
			step_s[0].st   <= x_s2;
			step_s[0].ct   <= 33'h1_0000_0000;
			step_s[0].s    <= {1'b0, x_s2};
			step_s[0].c    <= 33'h1_0000_0000;
			step_s[0].quad <= quad_s2;
			step_s[0].swap <= swap_s2;
		end
	end

	for (genvar g = 1; g <= epam_pkg::TERMS; g++) begin : g_term
		localparam logic [31:0] D_S = 32'(2 * g * (2 * g + 1));
		localparam logic [31:0] D_C = 32'((2 * g - 1) * (2 * g));
		localparam logic [31:0] M_S = 32'((64'd1 << 32) / D_S);
		localparam logic [31:0] M_C = 32'((64'd1 << 32) / D_C);

		logic [31:0]    ps_s1, pc_s1, ps_s2, pc_s2, qs_s2, qc_s2;
		epam_pkg::trm_t car_s1, car_s2, nxt_w;
		logic [63:0]    ms_w, mc_w, rs_w, rc_w;
		logic [31:0]    es_w, ec_w, ts_w, tc_w;

		assign ms_w = 64'(step_s[g-1].st) * 64'(step_s[g-1].x2);
		assign mc_w = 64'(step_s[g-1].ct) * 64'(step_s[g-1].x2);
		assign rs_w = 64'(ps_s1) * 64'(M_S);
		assign rc_w = 64'(pc_s1) * 64'(M_C);

		// reciprocal estimate is low by at most one
		assign es_w = ps_s2 - qs_s2 * D_S;
		assign ec_w = pc_s2 - qc_s2 * D_C;
		assign ts_w = qs_s2 + 32'(es_w >= D_S);
		assign tc_w = qc_s2 + 32'(ec_w >= D_C);

		always_comb begin
			nxt_w    = car_s2;
			nxt_w.st = ts_w;
			nxt_w.ct = 33'(tc_w);
			if (g % 2 == 1) begin
				nxt_w.s = car_s2.s - 33'(ts_w);
				nxt_w.c = car_s2.c - 33'(tc_w);
			end else begin
				nxt_w.s = car_s2.s + 33'(ts_w);
				nxt_w.c = car_s2.c + 33'(tc_w);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ps_s1     <= ms_w[63:32];
				pc_s1     <= mc_w[63:32];
				car_s1    <= step_s[g-1];
				qs_s2     <= rs_w[63:32];
				qc_s2     <= rc_w[63:32];
				ps_s2     <= ps_s1;
				pc_s2     <= pc_s1;
				car_s2    <= car_s1;
				step_s[g] <= nxt_w;
			end
		end
	end

	epam_pkg::trm_t          fin_w;
	logic [32:0]             sq_w, cq_w, sr_w, cr_w;
	logic signed [TRIG_BITS+1:0] sm_w, cm_w;

	assign fin_w = step_s[epam_pkg::TERMS];
	assign sq_w  = fin_w.swap ? fin_w.c : fin_w.s;
	assign cq_w  = fin_w.swap ? fin_w.s : fin_w.c;
	assign sr_w  = sq_w + (33'(1) << (RS - 1));
	assign cr_w  = cq_w + (33'(1) << (RS - 1));
	assign sm_w  = (TRIG_BITS+2)'(sr_w[32:RS]);
	assign cm_w  = (TRIG_BITS+2)'(cr_w[32:RS]);

	always_ff @(posedge clk) begin
		if (en) begin
			case (fin_w.quad)
				2'd0: begin
					sine   <= sm_w;
					cosine <= cm_w;
				end
				2'd1: begin
					sine   <= cm_w;
					cosine <= -sm_w;
				end
				2'd2: begin
					sine   <= -sm_w;
					cosine <= -cm_w;
				end
				default: begin
					sine   <= -cm_w;
					cosine <= sm_w;
				end
			endcase
		end
	end

endmodule

[rtl/epam_mat.sv]
`timescale 1ns / 1ps
// Rotation build R = Ry*Rx*Rz, scale multiply, rounding and saturation;
// six register stages. Uses epam_pkg.
module epam_mat #(
	parameter int TRIG_BITS = epam_pkg::TRIG_BITS
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [TRIG_BITS+1:0] sz,
	input  logic signed [TRIG_BITS+1:0] cz,
	input  logic signed [TRIG_BITS+1:0] sx,
	input  logic signed [TRIG_BITS+1:0] cx,
	input  logic signed [TRIG_BITS+1:0] sy,
	input  logic signed [TRIG_BITS+1:0] cy,
	input  epam_pkg::side_t             side,
	output epam_pkg::mtx_t              res
);

	localparam int RW = TRIG_BITS + 3;
	localparam int PW = 2 * RW;
	localparam int SW = PW + 1;
	localparam int KW = RW + 32;

	localparam logic signed [SW:0] HALF_S = (SW+1)'(1) <<< (TRIG_BITS - 1);
	localparam logic signed [KW:0] HALF_K = (KW+1)'(1) <<< (TRIG_BITS - 1);
	localparam logic signed [KW:0] MAX_K  = (KW+1)'(64'sd2147483647);
	localparam logic signed [KW:0] MIN_K  = (KW+1)'(-64'sd2147483648);

	function automatic logic signed [RW-1:0] rnd(input logic signed [SW-1:0] v);
		logic signed [SW:0] t;
		t = (SW+1)'(v) + HALF_S;
		t = t >>> TRIG_BITS;
		return RW'(t);
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [KW-1:0] v);
		logic signed [KW:0] t;
		t = (KW+1)'(v) + HALF_K;
		t = t >>> TRIG_BITS;
		if (t > MAX_K) begin
			return 32'sh7FFF_FFFF;
		end else if (t < MIN_K) begin
			return -32'sh8000_0000;
		end
		return t[31:0];
	endfunction

	logic signed [RW-1:0] sz_w, cz_w, sx_w, cx_w, sy_w, cy_w;

	assign sz_w = RW'(sz);
	assign cz_w = RW'(cz);
	assign sx_w = RW'(sx);
	assign cx_w = RW'(cx);
	assign sy_w = RW'(sy);
	assign cy_w = RW'(cy);

	logic signed [PW-1:0] sxsz_s1, sxcz_s1;
	logic signed [PW-1:0] cycz_s1, cysz_s1, sycz_s1, sysz_s1, sycx_s1, cxsz_s1, cxcz_s1, cycx_s1;
	logic signed [RW-1:0] sy_s1, cy_s1, sx_s1;
	logic signed [RW-1:0] sxsz_s2, sxcz_s2, sy_s2, cy_s2, sx_s2;
	logic signed [PW-1:0] cycz_s2, cysz_s2, sycz_s2, sysz_s2, sycx_s2, cxsz_s2, cxcz_s2, cycx_s2;
	logic signed [PW-1:0] a0_s3, a1_s3, a6_s3, a7_s3;
	logic signed [PW-1:0] cycz_s3, cysz_s3, sycz_s3, sysz_s3, sycx_s3, cxsz_s3, cxcz_s3, cycx_s3;
	logic signed [RW-1:0] sx_s3;
	logic signed [RW-1:0] r_s4  [0:8];
	logic signed [KW-1:0] rk_s5 [0:8];
	epam_pkg::side_t      side_s [1:5];

	always_ff @(posedge clk) begin
		if (en) begin
			sxsz_s1 <= PW'(sx_w) * PW'(sz_w);
			sxcz_s1 <= PW'(sx_w) * PW'(cz_w);
			cycz_s1 <= PW'(cy_w) * PW'(cz_w);
			cysz_s1 <= PW'(cy_w) * PW'(sz_w);
			sycz_s1 <= PW'(sy_w) * PW'(cz_w);
			sysz_s1 <= PW'(sy_w) * PW'(sz_w);
			sycx_s1 <= PW'(sy_w) * PW'(cx_w);
			cxsz_s1 <= PW'(cx_w) * PW'(sz_w);
			cxcz_s1 <= PW'(cx_w) * PW'(cz_w);
			cycx_s1 <= PW'(cy_w) * PW'(cx_w);
			sy_s1   <= sy_w;
			cy_s1   <= cy_w;
			sx_s1   <= sx_w;

			sxsz_s2 <= rnd(SW'(sxsz_s1));
			sxcz_s2 <= rnd(SW'(sxcz_s1));
			cycz_s2 <= cycz_s1;
			cysz_s2 <= cysz_s1;
			sycz_s2 <= sycz_s1;
			sysz_s2 <= sysz_s1;
			sycx_s2 <= sycx_s1;
			cxsz_s2 <= cxsz_s1;
			cxcz_s2 <= cxcz_s1;
			cycx_s2 <= cycx_s1;
			sy_s2   <= sy_s1;
			cy_s2   <= cy_s1;
			sx_s2   <= sx_s1;

			a0_s3   <= PW'(sy_s2) * PW'(sxsz_s2);
			a1_s3   <= PW'(sy_s2) * PW'(sxcz_s2);
			a6_s3   <= PW'(cy_s2) * PW'(sxsz_s2);
			a7_s3   <= PW'(cy_s2) * PW'(sxcz_s2);
			cycz_s3 <= cycz_s2;
			cysz_s3 <= cysz_s2;
			sycz_s3 <= sycz_s2;
			sysz_s3 <= sysz_s2;
			sycx_s3 <= sycx_s2;
			cxsz_s3 <= cxsz_s2;
			cxcz_s3 <= cxcz_s2;
			cycx_s3 <= cycx_s2;
			sx_s3   <= sx_s2;

			// each entry but r_s4[5] is an exact sum or product passed through rnd; r_s4[5] is -sx unrounded
			r_s4[0] <= rnd(SW'(cycz_s3) + SW'(a0_s3));
			r_s4[1] <= rnd(SW'(a1_s3) - SW'(cysz_s3));
			r_s4[2] <= rnd(SW'(sycx_s3));
			r_s4[3] <= rnd(SW'(cxsz_s3));
			r_s4[4] <= rnd(SW'(cxcz_s3));
			r_s4[5] <= -sx_s3;
			r_s4[6] <= rnd(SW'(a6_s3) - SW'(sycz_s3));
			r_s4[7] <= rnd(SW'(sysz_s3) + SW'(a7_s3));
			r_s4[8] <= rnd(SW'(cycx_s3));

			for (int i = 0; i < 9; i++) begin
				rk_s5[i] <= KW'(r_s4[i]) * KW'(side_s[4].k);
			end

			res.m00 <= sat(rk_s5[0]);
			res.m01 <= sat(rk_s5[1]);
			res.m02 <= sat(rk_s5[2]);
			res.m03 <= side_s[5].ox;
			res.m10 <= sat(rk_s5[3]);
			res.m11 <= sat(rk_s5[4]);
			res.m12 <= sat(rk_s5[5]);
			res.m13 <= side_s[5].oy;
			res.m20 <= sat(rk_s5[6]);
			res.m21 <= sat(rk_s5[7]);
			res.m22 <= sat(rk_s5[8]);
			res.m23 <= side_s[5].oz;

			side_s[1] <= side;
			for (int i = 2; i <= 5; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

endmodule

[rtl/euler_pose_to_affine_matrix.sv]
`timescale 1ns / 1ps
// Euler pose (roll Z, pitch X, yaw Y, scale, origin) to 3x4 affine matrix.
// Throughput: one request per cycle; a 2-entry output queue takes results
// while out_stall is high, and in_stall rises only when that queue is full.
// Reset (arst_n low, asynchronous): pipeline valid bits and queue cleared.
module euler_pose_to_affine_matrix #(
	parameter int ANGLE_BITS = epam_pkg::ANGLE_BITS,
	parameter int TRIG_BITS  = epam_pkg::TRIG_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        roll_angle,
	input  logic [15:0]        pitch_angle,
	input  logic [15:0]        yaw_angle,
	input  logic signed [31:0] scale_factor,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m03,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m13,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic signed [31:0] m23
);

	localparam int TOTAL_LAT = epam_pkg::TRIG_LAT + epam_pkg::MAT_LAT;
	localparam logic [1:0] QDEPTH = 2'd2;

	logic en, push, pop;
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic [TOTAL_LAT-1:0] vld_q;
	epam_pkg::side_t side_w;
	epam_pkg::side_t side_dly_q [0:epam_pkg::TRIG_LAT-1];
	epam_pkg::mtx_t  mat_w;
	epam_pkg::mtx_t  fifo_q [0:1];
	epam_pkg::mtx_t  head_w;
	logic signed [TRIG_BITS+1:0] sz_w, cz_w, sx_w, cx_w, sy_w, cy_w;

	// whole pipeline advances unless the output queue is full
	assign en       = (cnt_q != QDEPTH);
	assign in_stall = !en;
	assign push     = en && vld_q[TOTAL_LAT-1];
	assign pop      = out_valid && !out_stall;
	assign out_valid = (cnt_q != 2'd0);

	assign side_w.k  = scale_factor;
	assign side_w.ox = origin_x;
	assign side_w.oy = origin_y;
	assign side_w.oz = origin_z;

	epam_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_z (
		.clk(clk), .en(en), .angle(ANGLE_BITS'(roll_angle)), .sine(sz_w), .cosine(cz_w)
	);
	epam_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_x (
		.clk(clk), .en(en), .angle(ANGLE_BITS'(pitch_angle)), .sine(sx_w), .cosine(cx_w)
	);
	epam_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_y (
		.clk(clk), .en(en), .angle(ANGLE_BITS'(yaw_angle)), .sine(sy_w), .cosine(cy_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= side_w;
			for (int i = 1; i < epam_pkg::TRIG_LAT; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
		end
	end

	epam_mat #(.TRIG_BITS(TRIG_BITS)) u_mat (
		.clk(clk), .en(en),
		.sz(sz_w), .cz(cz_w), .sx(sx_w), .cx(cx_w), .sy(sy_w), .cy(cy_w),
		.side(side_dly_q[epam_pkg::TRIG_LAT-1]),
		.res(mat_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
			end
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= mat_w;
		end
	end

	assign head_w = fifo_q[rd_q];
	assign m00 = head_w.m00;
	assign m01 = head_w.m01;
	assign m02 = head_w.m02;
	assign m03 = head_w.m03;
	assign m10 = head_w.m10;
	assign m11 = head_w.m11;
	assign m12 = head_w.m12;
	assign m13 = head_w.m13;
	assign m20 = head_w.m20;
	assign m21 = head_w.m21;
	assign m22 = head_w.m22;
	assign m23 = head_w.m23;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue count did not drop on pop");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not rise on push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_q != rd_q))
		else $error("queue pointers disagree with count");

endmodule

[tb/tb_euler_pose_to_affine_matrix.sv]
`timescale 1ns / 1ps
// Testbench for euler_pose_to_affine_matrix: random and directed poses are checked
// against a fixed-point predictor of the scaled rotation and origin. Depends on epam_pkg and the RTL.
module tb_euler_pose_to_affine_matrix;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic signed [31:0] k;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid;
	pose_t cur = '0;
	epam_pkg::mtx_t got;

	pose_t pending_poses[$];
	epam_pkg::mtx_t expected_matrices[$];
	int mismatches = 0;
	int in_idle_pct = 23;
	int out_idle_pct = 54;
	int hold_cycles = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	bit stim_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	euler_pose_to_affine_matrix u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.roll_angle(cur.roll), .pitch_angle(cur.pitch), .yaw_angle(cur.yaw),
		.scale_factor(cur.k), .origin_x(cur.ox), .origin_y(cur.oy), .origin_z(cur.oz),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(got.m00), .m01(got.m01), .m02(got.m02), .m03(got.m03),
		.m10(got.m10), .m11(got.m11), .m12(got.m12), .m13(got.m13),
		.m20(got.m20), .m21(got.m21), .m22(got.m22), .m23(got.m23)
	);

	function automatic longint rnd_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// sine/cosine magnitudes on [0, pi/4], Q32 truncated Taylor terms
	function automatic void octant_series(logic [63:0] x, output logic [63:0] s,
		output logic [63:0] c);
		logic [63:0] x2, st, ct;
		x2 = (x * x) >> 32;
		st = x; s = x;
		ct = 64'd1 << 32; c = ct;
		for (int n = 1; n <= 7; n++) begin
			st = ((st * x2) >> 32) / ((2 * n) * (2 * n + 1));
			ct = ((ct * x2) >> 32) / ((2 * n - 1) * (2 * n));
			if (n & 1) begin
				s -= st; c -= ct;
			end else begin
				s += st; c += ct;
			end
		end
	endfunction

	function automatic longint trig_round(logic [63:0] m, bit neg);
		longint r;
		r = longint'((m + (64'd1 << (31 - epam_pkg::TRIG_BITS))) >>
			(32 - epam_pkg::TRIG_BITS));
		return neg ? -r : r;
	endfunction

	function automatic void sin_cos(logic [15:0] ang, output longint sn, output longint cs);
		logic [63:0] a, u, phi, x, s, c, sq, cq;
		logic [1:0] q;
		bit swap;
		a = 64'(ang) << (32 - epam_pkg::ANGLE_BITS);
		q = a[31:30];
		u = a & 64'h3FFF_FFFF;
		swap = u >= 64'h2000_0000;
		phi = swap ? 64'h4000_0000 - u : u;
		x = (phi * epam_pkg::PI_Q32 + (64'd1 << 30)) >> 31;
		octant_series(x, s, c);
		sq = swap ? c : s;
		cq = swap ? s : c;
		case (q)
			2'd0: begin sn = trig_round(sq, 0); cs = trig_round(cq, 0); end
			2'd1: begin sn = trig_round(cq, 0); cs = trig_round(sq, 1); end
			2'd2: begin sn = trig_round(sq, 1); cs = trig_round(cq, 1); end
			default: begin sn = trig_round(cq, 1); cs = trig_round(sq, 0); end
		endcase
	endfunction

	function automatic logic signed [31:0] scale_sat(longint r, longint k);
		longint v;
		v = rnd_shift(r * k, epam_pkg::TRIG_BITS);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic epam_pkg::mtx_t pose_matrix(pose_t p);
		longint sz, cz, sx, cx, sy, cy, k, sxsz, sxcz;
		longint r[9];
		epam_pkg::mtx_t m;
		sin_cos(p.roll, sz, cz);
		sin_cos(p.pitch, sx, cx);
		sin_cos(p.yaw, sy, cy);
		k = p.k;
		sxsz = rnd_shift(sx * sz, epam_pkg::TRIG_BITS);
		sxcz = rnd_shift(sx * cz, epam_pkg::TRIG_BITS);
		r[0] = rnd_shift(cy * cz + sy * sxsz, epam_pkg::TRIG_BITS);
		r[1] = rnd_shift(-cy * sz + sy * sxcz, epam_pkg::TRIG_BITS);
		r[2] = rnd_shift(sy * cx, epam_pkg::TRIG_BITS);
		r[3] = rnd_shift(cx * sz, epam_pkg::TRIG_BITS);
		r[4] = rnd_shift(cx * cz, epam_pkg::TRIG_BITS);
		r[5] = -sx;
		r[6] = rnd_shift(-sy * cz + cy * sxsz, epam_pkg::TRIG_BITS);
		r[7] = rnd_shift(sy * sz + cy * sxcz, epam_pkg::TRIG_BITS);
		r[8] = rnd_shift(cy * cx, epam_pkg::TRIG_BITS);
		m.m00 = scale_sat(r[0], k); m.m01 = scale_sat(r[1], k);
		m.m02 = scale_sat(r[2], k); m.m03 = p.ox;
		m.m10 = scale_sat(r[3], k); m.m11 = scale_sat(r[4], k);
		m.m12 = scale_sat(r[5], k); m.m13 = p.oy;
		m.m20 = scale_sat(r[6], k); m.m21 = scale_sat(r[7], k);
		m.m22 = scale_sat(r[8], k); m.m23 = p.oz;
		return m;
	endfunction

	function automatic logic [31:0] rnd_scale();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed(17'($urandom)) + 32'sd0);
		endcase
	endfunction

	// driver: the next request is offered from the queue, held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_poses.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
				cur <= pending_poses[0];
				expected_matrices.push_back(pose_matrix(pending_poses[0]));
				void'(pending_poses.pop_front());
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		epam_pkg::mtx_t exp_m;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_matrices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					exp_m = expected_matrices.pop_front();
					if (got !== exp_m) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h", exp_m, got);
					end
				end
			end
			out_stall <= hold_cycles > 0 || $urandom_range(0, 99) < out_idle_pct;
		end
	end

	// long hold-off of the receiver
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_cycles <= 80;
			hold_done <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	initial begin
		pose_t p;
		logic [15:0] corner[6];
		corner = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
		for (int i = 0; i < 6; i++) begin
			p.roll = corner[i]; p.pitch = corner[(i + 2) % 6]; p.yaw = corner[(i + 4) % 6];
			p.k = (i % 2) ? 32'sh0001_0000 : -32'sh0001_0000;
			p.ox = 32'h7FFF_FFFF; p.oy = 32'h8000_0000; p.oz = i;
			pending_poses.push_back(p);
		end
		// saturation in both directions and the extreme scales
		for (int i = 0; i < 6; i++) begin
			p.roll = corner[i]; p.pitch = 16'h1FFF; p.yaw = corner[5 - i];
			p.k = (i < 3) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			p.ox = 0; p.oy = -1; p.oz = 32'h5555_AAAA;
			pending_poses.push_back(p);
		end
		p = '0; p.k = 0;
		pending_poses.push_back(p);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				in_idle_pct = 54; out_idle_pct = 23;
			end else if (phase == 2) begin
				in_idle_pct = 0; out_idle_pct = 0;
			end
			for (int i = 0; i < 366; i++) begin
				p.roll = $urandom; p.pitch = $urandom; p.yaw = $urandom;
				p.k = rnd_scale();
				p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
				pending_poses.push_back(p);
			end
			if (phase == 2) begin
				@(posedge clk);
				hold_go = 1'b1;
			end
			wait (pending_poses.size() == 0);
		end
		@(posedge clk);
		while (in_valid && in_stall) @(posedge clk);
		wait (expected_matrices.size() == 0);
		repeat (40) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0 && expected_matrices.size() == 0)
			$display("tb_euler_pose_to_affine_matrix passed");
		else
			$display("tb_euler_pose_to_affine_matrix failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_euler_pose_to_affine_matrix failed");
		$finish;
	end

endmodule

[euler_pose_to_affine_matrix.f]
rtl/epam_pkg.sv
rtl/epam_trig.sv
rtl/epam_mat.sv
rtl/euler_pose_to_affine_matrix.sv
tb/tb_euler_pose_to_affine_matrix.sv
